// ===== src/cdce_pkg.sv =====
// ----------------------------------------------------------------------------
// cdce_pkg
// Shared types and constants for the command dedup cache: operation and
// status codes, sequencer states and default sizing.
// ----------------------------------------------------------------------------
package cdce_pkg;

    // Default sizing
    localparam int CDCE_ENTRIES     = 16;
    localparam int CDCE_DIGEST_BITS = 64;
    localparam int CDCE_RESULT_MAX  = 256;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int TOKEN_W   = 64;
    localparam int CMD_W     = 16;
    localparam int DIGIN_W   = 64;
    localparam int TIME_W    = 64;
    localparam int EIDX_W    = 8;
    localparam int SIZE_W    = 10;
    localparam int STATUS_W  = 3;
    localparam int HIT_W     = 4;
    localparam int SSIZE_W   = 9;
    localparam int LIFE_W    = 27;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 27'd60000;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADMIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_ACK    = 3'd2;
    localparam logic [OP_W-1:0] OP_RECORD = 3'd3;
    localparam logic [OP_W-1:0] OP_EXPIRE = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STALE    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SCAN,
        S_FIN,
        S_SEND
    } t_state;

endpackage

// ===== src/command_dedup_cache_with_expiry.sv =====
// ----------------------------------------------------------------------------
// command_dedup_cache_with_expiry
// Table of recent command requests keyed by nonzero token, with expiry,
// for duplicate suppression.
// ----------------------------------------------------------------------------
// One command word is taken at a time. After acceptance the block first
// forms the renewed expiry time (now plus lifetime, saturating) in the calc
// state, then admit, lookup and expire-all walk the table one slot per cycle
// through a single shared expiry comparator and token/digest matcher, with
// admit and lookup stopping early on a token match; the final step then
// applies the table update and forms the result word, and the send state
// loads it into the output register. The walk is made only for admit and
// lookup with a nonzero token and for expire-all; everything else goes from
// the calc state straight to the final step. Ready comes back in the same
// cycle as the result word, so a new command word is taken only after the
// previous one is through; the send state waits while the output register
// still holds a result word that has not been taken.
// The table is empty after reset with no clearing pass. Mark acknowledged
// only reports whether the slot holds a valid entry, without an expiry test.
// The lifetime register may be written at any cycle while no command word
// is in flight.
module command_dedup_cache_with_expiry
    import cdce_pkg::*;
#(
    parameter int ENTRIES     = CDCE_ENTRIES,
    parameter int DIGEST_BITS = CDCE_DIGEST_BITS,
    parameter int RESULT_MAX  = CDCE_RESULT_MAX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [LIFE_W-1:0]   i_cfg_data,
    // command channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [TOKEN_W-1:0]  i_request_token,
    input  logic [CMD_W-1:0]    i_command_id,
    input  logic [DIGIN_W-1:0]  i_arg_digest,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [EIDX_W-1:0]   i_entry_index,
    input  logic [SIZE_W-1:0]   i_result_size,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [HIT_W-1:0]    o_hit_index,
    output logic                o_has_result,
    output logic [SSIZE_W-1:0]  o_stored_size
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEN_W = $clog2(RESULT_MAX + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Table storage
    logic [ENTRIES-1:0]     r_valid;
    logic [ENTRIES-1:0]     r_terminal;
    logic [TOKEN_W-1:0]     r_token_tab  [ENTRIES];
    logic [CMD_W-1:0]       r_cmd_tab    [ENTRIES];
    logic [DIGEST_BITS-1:0] r_dig_tab    [ENTRIES];
    logic [TIME_W-1:0]      r_exp_tab    [ENTRIES];
    logic [LEN_W-1:0]       r_len_tab    [ENTRIES];

    // Control and captured command
    t_state                 r_state, n_state;
    logic [LIFE_W-1:0]      r_lifetime;
    logic [OP_W-1:0]        r_op;
    logic [TOKEN_W-1:0]     r_token;
    logic [CMD_W-1:0]       r_cmd;
    logic [DIGEST_BITS-1:0] r_dig;
    logic [TIME_W-1:0]      r_now;
    logic [EIDX_W-1:0]      r_tgt;
    logic [SIZE_W-1:0]      r_size;
    logic [TIME_W-1:0]      r_exp_new;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_match;
    logic                   r_mis;
    logic [IDX_W-1:0]       r_hit;
    logic                   r_has;
    logic [LEN_W-1:0]       r_len;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free;

    // Result word held for the send state and output register
    logic [STATUS_W-1:0]    r_res_status;
    logic [HIT_W-1:0]       r_res_hit;
    logic                   r_res_has;
    logic [SSIZE_W-1:0]     r_res_size;
    logic                   r_o_valid;
    logic [STATUS_W-1:0]    r_o_status;
    logic [HIT_W-1:0]       r_o_hit;
    logic                   r_o_has;
    logic [SSIZE_W-1:0]     r_o_size;

    // State decodes
    logic w_accept, w_calc, w_scan, w_fin, w_load;
    logic w_in_ready;

    // Shared comparator and matcher
    logic [IDX_W-1:0]  w_cmp_idx;
    logic              w_expired;
    logic              w_live;
    logic              w_tok_eq;
    logic              w_same;
    logic              w_scan_match;
    logic              w_scan_last;
    logic [TIME_W:0]   w_sum;
    logic              w_is_scan_op;

    // Final-step decisions
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0]    w_hit_slot;
    logic                w_hit_en;
    logic                w_has;
    logic [LEN_W-1:0]    w_len;
    logic                w_ins_en;
    logic                w_rec_en;
    logic                w_kill_en;
    logic                w_tgt_ok;
    logic                w_size_ok;
    logic [IDX_W-1:0]    w_tgt;
    logic [7:0]          w_hit8;
    logic [SIZE_W-1:0]   w_len10;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = w_is_scan_op ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                if (w_scan_match || w_scan_last) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (!r_o_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_calc     = 1'b0;
        w_scan     = 1'b0;
        w_fin      = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE: w_in_ready = 1'b1;
            S_CALC: w_calc     = 1'b1;
            S_SCAN: w_scan     = 1'b1;
            S_FIN:  w_fin      = 1'b1;
            S_SEND: w_load     = !r_o_valid || i_ready;
            default: w_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_valid && w_in_ready;
    assign o_ready  = w_in_ready;

    // Walk only for admit and lookup with a nonzero token, and for expire all
    assign w_is_scan_op = ((r_op == OP_ADMIT || r_op == OP_LOOKUP) && (r_token != '0))
                          || (r_op == OP_EXPIRE);

    // Renewed expiry, saturating at the top of the time range
    assign w_sum = {1'b0, r_now} + (TIME_W + 1)'(r_lifetime);

    // Shared expiry compare and key match on the selected slot
    assign w_tgt     = r_tgt[IDX_W-1:0];
    assign w_cmp_idx = w_scan ? r_idx : w_tgt;
    assign w_expired = r_valid[w_cmp_idx] && (r_exp_tab[w_cmp_idx] <= r_now);
    assign w_live    = r_valid[w_cmp_idx] && !w_expired;
    assign w_tok_eq  = (r_token_tab[w_cmp_idx] == r_token);
    assign w_same    = (r_cmd_tab[w_cmp_idx] == r_cmd) && (r_dig_tab[w_cmp_idx] == r_dig);
    assign w_scan_match = w_live && w_tok_eq && (r_op != OP_EXPIRE);
    assign w_scan_last  = (r_idx == LAST_IDX);

    // Range checks for the slot-addressed operations
    assign w_tgt_ok  = ({1'b0, r_tgt} < (EIDX_W + 1)'(ENTRIES));
    assign w_size_ok = (r_size != '0) && (r_size <= SIZE_W'(RESULT_MAX));

    // Decide the answer and the table update of the final step
    always_comb begin
        w_status   = STAT_INVALID;
        w_hit_slot = r_hit;
        w_hit_en   = 1'b0;
        w_has      = 1'b0;
        w_len      = '0;
        w_ins_en   = 1'b0;
        w_rec_en   = 1'b0;
        w_kill_en  = 1'b0;
        case (r_op)
            OP_ADMIT: begin
                if (r_token != '0) begin
                    if (r_match) begin
                        w_status = r_mis ? STAT_MISMATCH : STAT_DUP;
                        w_hit_en = 1'b1;
                    end else if (r_free_found) begin
                        w_status   = STAT_OK;
                        w_hit_slot = r_free;
                        w_hit_en   = 1'b1;
                        w_ins_en   = 1'b1;
                    end else begin
                        w_status = STAT_BUSY;
                    end
                end
            end
            OP_LOOKUP: begin
                if (r_token != '0) begin
                    if (r_match) begin
                        w_status = r_mis ? STAT_MISMATCH : STAT_DUP;
                        w_hit_en = 1'b1;
                        w_has    = r_has;
                        w_len    = r_has ? r_len : '0;
                    end else begin
                        w_status = STAT_STALE;
                    end
                end
            end
            OP_ACK: begin
                if (w_tgt_ok) begin
                    w_status = r_valid[w_tgt] ? STAT_OK : STAT_STALE;
                end
            end
            OP_RECORD: begin
                if (w_tgt_ok && w_size_ok) begin
                    if (w_live) begin
                        w_status = STAT_OK;
                        w_rec_en = 1'b1;
                    end else begin
                        w_status  = STAT_STALE;
                        w_kill_en = 1'b1;
                    end
                end
            end
            OP_EXPIRE: begin
                w_status = STAT_OK;
            end
            default: begin
                w_status = STAT_INVALID;
            end
        endcase
    end

    assign w_hit8  = 8'(w_hit_slot);
    assign w_len10 = SIZE_W'(w_len);

    // Control: sequencer, valid bits, walk index, output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lifetime <= LIFETIME_RESET;
            r_valid    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_lifetime <= i_cfg_data;
            // drop expired slots as the walk passes them
            if (w_scan && w_expired) r_valid[r_idx] <= 1'b0;
            if (w_fin && w_ins_en) r_valid[r_free] <= 1'b1;
            if (w_fin && w_kill_en) r_valid[w_tgt] <= 1'b0;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath: captured command, walk bookkeeping, table payload, results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_token  <= i_request_token;
            r_cmd    <= i_command_id;
            r_dig    <= i_arg_digest[DIGEST_BITS-1:0];
            r_now    <= i_now_ms;
            r_tgt    <= i_entry_index;
            r_size   <= i_result_size;
        end
        // form renewed expiry and reset walk bookkeeping
        if (w_calc) begin
            r_exp_new    <= w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
            r_idx        <= '0;
            r_match      <= 1'b0;
            r_free_found <= 1'b0;
        end
        // advance the walk, note first free slot and any match
        if (w_scan) begin
            if (!w_scan_last) r_idx <= r_idx + 1'b1;
            if (!w_live && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free       <= r_idx;
            end
            if (w_scan_match) begin
                r_match <= 1'b1;
                r_mis   <= !w_same;
                r_hit   <= r_idx;
                r_has   <= w_same && r_terminal[r_idx];
                r_len   <= r_len_tab[r_idx];
            end
        end
        // apply insert or result record
        if (w_fin && w_ins_en) begin
            r_token_tab[r_free] <= r_token;
            r_cmd_tab[r_free]   <= r_cmd;
            r_dig_tab[r_free]   <= r_dig;
            r_exp_tab[r_free]   <= r_exp_new;
            r_len_tab[r_free]   <= '0;
            r_terminal[r_free]  <= 1'b0;
        end
        if (w_fin && w_rec_en) begin
            r_len_tab[w_tgt]  <= LEN_W'(r_size);
            r_terminal[w_tgt] <= 1'b1;
            r_exp_tab[w_tgt]  <= r_exp_new;
        end
        if (w_fin) begin
            r_res_status <= w_status;
            r_res_hit    <= w_hit_en ? w_hit8[HIT_W-1:0] : '0;
            r_res_has    <= w_has;
            r_res_size   <= w_len10[SSIZE_W-1:0];
        end
        // hold the result word until taken
        if (w_load) begin
            r_o_status <= r_res_status;
            r_o_hit    <= r_res_hit;
            r_o_has    <= r_res_has;
            r_o_size   <= r_res_size;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_hit_index   = r_o_hit;
    assign o_has_result  = r_o_has;
    assign o_stored_size = r_o_size;

endmodule

// ===== src/cdce_checker.sv =====
// ----------------------------------------------------------------------------
// cdce_checker
// Port-level checks for the command dedup cache, bound to the top level.
// ----------------------------------------------------------------------------
module cdce_checker
    import cdce_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [HIT_W-1:0]    o_hit_index,
    input logic                o_has_result,
    input logic [SSIZE_W-1:0]  o_stored_size
);

    // A stored result is only reported on a clean duplicate
    a_has_is_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_result |-> o_status == STAT_DUP)
        else $error("has_result without duplicate status");

    // A reported result carries a nonzero size, an absent one carries none
    a_size_tracks_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_has_result ? (o_stored_size != '0) : (o_stored_size == '0)))
        else $error("stored_size disagrees with has_result");

    // Failed answers point at no slot
    a_no_hit_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_BUSY || o_status == STAT_STALE ||
                    o_status == STAT_INVALID) |-> o_hit_index == '0)
        else $error("hit_index set on a failed answer");

    // Block is busy right after taking a command word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a command word was taken");

endmodule

bind command_dedup_cache_with_expiry cdce_checker u_cdce_checker (.*);

// ===== verif/tb_command_dedup_cache_with_expiry.sv =====
// ----------------------------------------------------------------------------
// tb_command_dedup_cache_with_expiry
// Self-checking bench for the command dedup cache. A tracker class keeps its
// own copy of the token table and the lifetime register, works out the reply
// to every accepted command word and checks replies in order. Stimulus is a
// directed opening over the corner cases, then phases of random commands
// drawn from a token pool under several lifetime settings, with random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_command_dedup_cache_with_expiry;
    import cdce_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 108;
    localparam int POOL_SIZE      = 20;
    localparam int MAX_REPORTS    = 10;

    localparam logic [DIGIN_W-1:0] DIG_MASK = {DIGIN_W{1'b1}} >> (DIGIN_W - CDCE_DIGEST_BITS);
    localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};
    localparam logic [LIFE_W-1:0]  LIFE_TOP = 27'd86400000;
    localparam logic [LIFE_W-1:0]  LIFE_ALL = {LIFE_W{1'b1}};

    // Codes the block has no meaning for
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TOKEN_W-1:0] token;
        logic [CMD_W-1:0]   cmd;
        logic [DIGIN_W-1:0] dig;
        logic [TIME_W-1:0]  now;
        logic [EIDX_W-1:0]  idx;
        logic [SIZE_W-1:0]  size;
    } t_cmd_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HIT_W-1:0]    hit;
        logic                has;
        logic [SSIZE_W-1:0]  ssize;
    } t_reply_word;

    // ------------------------------------------------------------------------
    // Table tracker: mirrors the cache and checks replies in order
    // ------------------------------------------------------------------------
    class dedup_checker;
        logic [LIFE_W-1:0]  lifetime;
        bit                 ent_live  [CDCE_ENTRIES];
        bit                 ent_acked [CDCE_ENTRIES];
        bit                 ent_term  [CDCE_ENTRIES];
        logic [TOKEN_W-1:0] ent_tok   [CDCE_ENTRIES];
        logic [CMD_W-1:0]   ent_cmd   [CDCE_ENTRIES];
        logic [DIGIN_W-1:0] ent_dig   [CDCE_ENTRIES];
        logic [TIME_W-1:0]  ent_exp   [CDCE_ENTRIES];
        logic [SSIZE_W-1:0] ent_rlen  [CDCE_ENTRIES];
        t_reply_word        pending_replies [$];
        int                 mismatches;

        function new();
            lifetime   = LIFETIME_RESET;
            mismatches = 0;
            for (int i = 0; i < CDCE_ENTRIES; i++) begin
                wipe(i);
            end
        endfunction

        function void wipe(int i);
            ent_live[i]  = 1'b0;
            ent_acked[i] = 1'b0;
            ent_term[i]  = 1'b0;
            ent_tok[i]   = '0;
            ent_cmd[i]   = '0;
            ent_dig[i]   = '0;
            ent_exp[i]   = '0;
            ent_rlen[i]  = '0;
        endfunction

        function bit expired(int i, logic [TIME_W-1:0] now);
            return ent_live[i] && (ent_exp[i] <= now);
        endfunction

        // now plus lifetime, clamped at the top of the time range
        function logic [TIME_W-1:0] renewed_expiry(logic [TIME_W-1:0] now);
            logic [TIME_W:0] sum;
            sum = {1'b0, now} + {{(TIME_W + 1 - LIFE_W){1'b0}}, lifetime};
            return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        endfunction

        function void set_lifetime(logic [LIFE_W-1:0] v);
            lifetime = v;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function string reply_text(t_reply_word r);
            return $sformatf("status=%0d hit=%0d has=%0d size=%0d",
                             r.status, r.hit, r.has, r.ssize);
        endfunction

        // Apply one command to the table and form its reply
        function t_reply_word apply_command(t_cmd_word c);
            t_reply_word        r;
            logic [DIGIN_W-1:0] dig;
            int                 free_slot;
            int                 e;
            bit                 done;
            r        = '0;
            r.status = STAT_INVALID;
            dig      = c.dig & DIG_MASK;
            e        = int'(c.idx);
            done     = 1'b0;
            case (c.op)
                OP_ADMIT: begin
                    if (c.token != '0) begin
                        free_slot = CDCE_ENTRIES;
                        for (int i = 0; i < CDCE_ENTRIES && !done; i++) begin
                            if (expired(i, c.now)) wipe(i);
                            if (!ent_live[i]) begin
                                if (free_slot == CDCE_ENTRIES) free_slot = i;
                            end else if (ent_tok[i] == c.token) begin
                                r.hit    = HIT_W'(i);
                                r.status = (ent_cmd[i] != c.cmd || ent_dig[i] != dig) ?
                                           STAT_MISMATCH : STAT_DUP;
                                done     = 1'b1;
                            end
                        end
                        if (!done) begin
                            if (free_slot == CDCE_ENTRIES) begin
                                r.status = STAT_BUSY;
                            end else begin
                                wipe(free_slot);
                                ent_live[free_slot] = 1'b1;
                                ent_tok[free_slot]  = c.token;
                                ent_cmd[free_slot]  = c.cmd;
                                ent_dig[free_slot]  = dig;
                                ent_exp[free_slot]  = renewed_expiry(c.now);
                                r.hit    = HIT_W'(free_slot);
                                r.status = STAT_OK;
                            end
                        end
                    end
                end
                OP_LOOKUP: begin
                    if (c.token != '0) begin
                        r.status = STAT_STALE;
                        for (int i = 0; i < CDCE_ENTRIES && !done; i++) begin
                            if (ent_live[i]) begin
                                if (expired(i, c.now)) begin
                                    wipe(i);
                                end else if (ent_tok[i] == c.token) begin
                                    r.hit = HIT_W'(i);
                                    if (ent_cmd[i] != c.cmd || ent_dig[i] != dig) begin
                                        r.status = STAT_MISMATCH;
                                    end else begin
                                        r.status = STAT_DUP;
                                        if (ent_term[i]) begin
                                            r.has   = 1'b1;
                                            r.ssize = ent_rlen[i];
                                        end
                                    end
                                    done = 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_ACK: begin
                    if (c.idx < CDCE_ENTRIES) begin
                        if (!ent_live[e]) begin
                            r.status = STAT_STALE;
                        end else begin
                            ent_acked[e] = 1'b1;
                            r.status     = STAT_OK;
                        end
                    end
                end
                OP_RECORD: begin
                    if (c.idx < CDCE_ENTRIES && c.size != '0 && c.size <= CDCE_RESULT_MAX) begin
                        if (!ent_live[e] || expired(e, c.now)) begin
                            if (ent_live[e]) wipe(e);
                            r.status = STAT_STALE;
                        end else begin
                            ent_rlen[e] = c.size[SSIZE_W-1:0];
                            ent_term[e] = 1'b1;
                            ent_exp[e]  = renewed_expiry(c.now);
                            r.status    = STAT_OK;
                        end
                    end
                end
                OP_EXPIRE: begin
                    for (int i = 0; i < CDCE_ENTRIES; i++) begin
                        if (expired(i, c.now)) wipe(i);
                    end
                    r.status = STAT_OK;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_command(t_cmd_word c);
            pending_replies.push_back(apply_command(c));
        endfunction

        function void check_reply(t_reply_word got);
            t_reply_word want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reply with nothing pending: %s", reply_text(got));
            end else begin
                want = pending_replies.pop_front();
                if (got.status != want.status || got.hit != want.hit ||
                    got.has != want.has || got.ssize != want.ssize) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("reply mismatch: exp %s, got %s",
                                 reply_text(want), reply_text(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [LIFE_W-1:0]   i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [OP_W-1:0]     i_op = '0;
    logic [TOKEN_W-1:0]  i_request_token = '0;
    logic [CMD_W-1:0]    i_command_id = '0;
    logic [DIGIN_W-1:0]  i_arg_digest = '0;
    logic [TIME_W-1:0]   i_now_ms = '0;
    logic [EIDX_W-1:0]   i_entry_index = '0;
    logic [SIZE_W-1:0]   i_result_size = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [HIT_W-1:0]    o_hit_index;
    logic                o_has_result;
    logic [SSIZE_W-1:0]  o_stored_size;

    command_dedup_cache_with_expiry u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_request_token (i_request_token),
        .i_command_id    (i_command_id),
        .i_arg_digest    (i_arg_digest),
        .i_now_ms        (i_now_ms),
        .i_entry_index   (i_entry_index),
        .i_result_size   (i_result_size),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_hit_index     (o_hit_index),
        .o_has_result    (o_has_result),
        .o_stored_size   (o_stored_size)
    );

    dedup_checker tracker = new();

    int                 idle_cycles = 0;
    int                 rx_hold_len = 0;
    int                 rx_stall = 0;
    int                 rx_calm = 0;
    int                 tx_calm = 0;
    logic [TIME_W-1:0]  cur_now = '0;
    int                 now_step = 1;
    logic [TOKEN_W-1:0] pool_tok [POOL_SIZE];
    logic [CMD_W-1:0]   pool_cmd [POOL_SIZE];
    logic [DIGIN_W-1:0] pool_dig [POOL_SIZE];

    // Clock: period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: note register writes and accepted words on both channels
    always @(posedge i_clk) begin
        t_cmd_word   c;
        t_reply_word q;
        if (i_rst_n) begin
            if (i_cfg_we) tracker.set_lifetime(i_cfg_data);
            if (i_valid && o_ready) begin
                c = '{i_op, i_request_token, i_command_id, i_arg_digest,
                      i_now_ms, i_entry_index, i_result_size};
                tracker.note_command(c);
            end
            if (o_valid && i_ready) begin
                q = '{o_status, o_hit_index, o_has_result, o_stored_size};
                tracker.check_reply(q);
            end
            idle_cycles = ((i_valid && o_ready) || (o_valid && i_ready)) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("** command_dedup_cache_with_expiry: FAILED **");
        $finish;
    end

    // Receiver: random stalls, calm stretches and an on-demand long hold-off
    initial begin
        int r;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_ready = 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            if (rx_stall > 0) begin
                i_ready = 1'b0;
                rx_stall--;
            end else if (rx_calm > 0) begin
                i_ready = 1'b1;
                rx_calm--;
            end else begin
                r = $urandom_range(0, 99);
                i_ready = (r >= 27);
                if (r < 18)      rx_stall = $urandom_range(0, 2);
                else if (r < 25) rx_stall = $urandom_range(3, 11);
                else if (r < 27) rx_stall = $urandom_range(19, 59);
                else if (r < 29) rx_calm  = $urandom_range(30, 100);
            end
        end
    end

    // Sender gap after a word: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        if (r < 97) begin
            tx_calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_cmd_word make_cmd(logic [OP_W-1:0] op, logic [TOKEN_W-1:0] token,
                                           logic [CMD_W-1:0] cmd, logic [DIGIN_W-1:0] dig,
                                           logic [TIME_W-1:0] now, logic [EIDX_W-1:0] idx,
                                           logic [SIZE_W-1:0] size);
        t_cmd_word c;
        c = '{op, token, cmd, dig, now, idx, size};
        return c;
    endfunction

    // One random command: mostly pool traffic on the running clock, some noise
    function automatic t_cmd_word random_cmd();
        t_cmd_word c;
        int        r;
        int        p;
        cur_now = cur_now + $urandom_range(0, now_step);
        p = $urandom_range(0, POOL_SIZE - 1);
        c = make_cmd(OP_ADMIT, pool_tok[p], pool_cmd[p], pool_dig[p], cur_now,
                     8'($urandom_range(0, CDCE_ENTRIES - 1)), 10'($urandom));
        r = $urandom_range(0, 99);
        if (r < 52) begin
            // admit or lookup, now and then with a changed command or digest
            c.op = (r < 32) ? OP_ADMIT : OP_LOOKUP;
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) c.cmd = c.cmd ^ (16'd1 << $urandom_range(0, 15));
                else                      c.dig = c.dig ^ (64'd1 << $urandom_range(0, 63));
            end
        end else if (r < 64) begin
            c.op = OP_ACK;
            if ($urandom_range(0, 7) == 0) c.idx = 8'($urandom);
        end else if (r < 80) begin
            c.op = OP_RECORD;
            if ($urandom_range(0, 7) == 0) c.idx = 8'($urandom);
            if ($urandom_range(0, 4) != 0) c.size = 10'($urandom_range(1, CDCE_RESULT_MAX));
        end else if (r < 85) begin
            c.op = OP_EXPIRE;
        end else if (r < 88) begin
            c.op  = 3'(OP_UNUSED_LO + $urandom_range(0, OP_UNUSED_HI - OP_UNUSED_LO));
            c.dig = rand64();
        end else if (r < 91) begin
            c.op    = $urandom_range(0, 1) ? OP_ADMIT : OP_LOOKUP;
            c.token = '0;
        end else begin
            // noise over every field
            c = make_cmd(3'($urandom), rand64(), 16'($urandom), rand64(),
                         $urandom_range(0, 1) ? rand64() : cur_now,
                         8'($urandom), 10'($urandom));
        end
        return c;
    endfunction

    // Offer one word and hold it until accepted, then leave a gap
    task automatic send_cmd(t_cmd_word c);
        int gap;
        i_op            = c.op;
        i_request_token = c.token;
        i_command_id    = c.cmd;
        i_arg_digest    = c.dig;
        i_now_ms        = c.now;
        i_entry_index   = c.idx;
        i_result_size   = c.size;
        i_valid         = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Hold the sender until every reply is back and the block is quiet
    task automatic drain();
        i_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_lifetime(logic [LIFE_W-1:0] v);
        drain();
        i_cfg_data = v;
        i_cfg_we   = 1'b1;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TOKEN_W-1:0] t1;
        logic [TOKEN_W-1:0] t2;
        logic [TOKEN_W-1:0] t4;
        logic [CMD_W-1:0]   c1;
        logic [DIGIN_W-1:0] d1;
        logic [LIFE_W-1:0]  life;
        logic [TIME_W-1:0]  far;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed opening at the reset lifetime
        t1  = TIME_MAX;
        t2  = 64'd1;
        t4  = 64'h5A5A_A5A5_0F0F_F0F0;
        c1  = 16'hFFFF;
        d1  = 64'hFFFF_FFFF_FFFF_FFFF;
        far = TIME_MAX - 64'd15;
        // zero token is refused by admit and lookup
        send_cmd(make_cmd(OP_ADMIT,  '0, c1, d1, 64'd100, '0, '0));
        send_cmd(make_cmd(OP_LOOKUP, '0, c1, d1, 64'd100, '0, '0));
        // insert, then duplicate and both kinds of mismatch
        send_cmd(make_cmd(OP_ADMIT,  t1, c1, d1, 64'd100, '0, '0));
        send_cmd(make_cmd(OP_ADMIT,  t1, c1, d1, 64'd110, '0, '0));
        send_cmd(make_cmd(OP_ADMIT,  t1, c1 ^ 16'h0001, d1, 64'd110, '0, '0));
        send_cmd(make_cmd(OP_LOOKUP, t1, c1, d1 ^ 64'h8000_0000_0000_0000, 64'd110, '0, '0));
        // second entry that expires first
        send_cmd(make_cmd(OP_ADMIT,  t2, '0, '0, 64'd50, '0, '0));
        // acknowledge: live, empty, index out of range
        send_cmd(make_cmd(OP_ACK, '0, '0, '0, 64'd120, 8'd0, '0));
        send_cmd(make_cmd(OP_ACK, '0, '0, '0, 64'd120, 8'd9, '0));
        send_cmd(make_cmd(OP_ACK, '0, '0, '0, 64'd120, 8'hFF, '0));
        // record: bad sizes, bad index, then a good one
        send_cmd(make_cmd(OP_RECORD, '0, '0, '0, 64'd120, 8'd0, 10'd0));
        send_cmd(make_cmd(OP_RECORD, '0, '0, '0, 64'd120, 8'd0, 10'd257));
        send_cmd(make_cmd(OP_RECORD, '0, '0, '0, 64'd120, 8'd0, 10'h3FF));
        send_cmd(make_cmd(OP_RECORD, '0, '0, '0, 64'd120, 8'd16, 10'd4));
        send_cmd(make_cmd(OP_RECORD, '0, '0, '0, 64'd120, 8'd0, 10'd256));
        // lookup stops at the match before the expired second entry
        send_cmd(make_cmd(OP_LOOKUP, t1, c1, d1, 64'd60060, '0, '0));
        // acknowledge skips the expiry test; record on the expired slot clears it
        send_cmd(make_cmd(OP_ACK,    '0, '0, '0, 64'd60060, 8'd1, '0));
        send_cmd(make_cmd(OP_RECORD, '0, '0, '0, 64'd60060, 8'd1, 10'd1));
        send_cmd(make_cmd(OP_ACK,    '0, '0, '0, 64'd60060, 8'd1, '0));
        // lookup miss
        send_cmd(make_cmd(OP_LOOKUP, t4, c1, d1, 64'd60060, '0, '0));
        // unknown codes
        send_cmd(make_cmd(OP_UNUSED_LO, t1, c1, d1, 64'd60060, 8'd0, 10'd8));
        send_cmd(make_cmd(OP_UNUSED_HI, rand64(), 16'($urandom), rand64(), rand64(),
                          8'($urandom), 10'($urandom)));
        // saturating expiry near the top of time, then expired at the top
        send_cmd(make_cmd(OP_ADMIT,  t4, 16'h0, 64'h0, far, '0, '0));
        send_cmd(make_cmd(OP_LOOKUP, t4, 16'h0, 64'h0, TIME_MAX, '0, '0));
        send_cmd(make_cmd(OP_EXPIRE, '0, '0, '0, TIME_MAX, '0, '0));

        // Random phases under several lifetimes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin life = LIFETIME_RESET; now_step = 7500;     cur_now = 64'd1000; end
                1: begin life = '0;             now_step = 1;        cur_now = rand64(); end
                2: begin life = 27'd1;          now_step = 2;        cur_now = 64'd0;    end
                3: begin life = LIFE_TOP;       now_step = 10000000; cur_now = 64'd0;    end
                4: begin life = LIFE_ALL;       now_step = 40;
                         cur_now = 64'hFFFF_FFFF_FC00_0000; end
                default: begin
                    life     = 27'($urandom_range(2, 5000));
                    now_step = int'(life) / 3 + 1;
                    cur_now  = 64'($urandom);
                end
            endcase
            if (ph == 0) drain();
            else         write_lifetime(life);
            // fresh token pool for each phase
            for (int p = 0; p < POOL_SIZE; p++) begin
                do pool_tok[p] = rand64(); while (pool_tok[p] == '0);
                pool_cmd[p] = 16'($urandom);
                pool_dig[p] = rand64() & DIG_MASK;
            end
            // long receiver hold-off against a back-to-back sender
            if (ph == 2) begin
                tx_calm     = 40;
                rx_hold_len = 150;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_cmd(random_cmd());
            end
        end

        // Drain and settle, then report
        drain();
        repeat (40) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("** command_dedup_cache_with_expiry: PASSED **");
        end else begin
            $display("** command_dedup_cache_with_expiry: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/cdce_pkg.sv
src/command_dedup_cache_with_expiry.sv
src/cdce_checker.sv
verif/tb_command_dedup_cache_with_expiry.sv
